[src/lapsp_pkg.sv]
`timescale 1ns / 1ps

package lapsp_pkg;

  // Store geometry: MAX_VERTICES + 1 layers of MAX_VERTICES x MAX_VERTICES entries.
  localparam int MAX_VERTICES = 16;
  localparam int PLANE        = MAX_VERTICES * MAX_VERTICES;
  localparam int STORE_DEPTH  = (MAX_VERTICES + 1) * PLANE;

  localparam int DIST_W  = 24;
  localparam int VTX_W   = 5;
  localparam int WGT_W   = 16;
  localparam int KIND_W  = 2;
  localparam int VIDX_W  = $clog2(MAX_VERTICES);
  localparam int LAYER_W = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int CMP_W   = (LAYER_W > VTX_W) ? LAYER_W : VTX_W;

  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [VIDX_W-1:0]  vidx_t;
  typedef logic [LAYER_W-1:0] layer_t;
  typedef logic [KIND_W-1:0]  kind_t;

  localparam dist_t DIST_INF = 24'd9999999;

  localparam kind_t KIND_CLEAR   = 2'd0;
  localparam kind_t KIND_EDGE    = 2'd1;
  localparam kind_t KIND_COMPUTE = 2'd2;
  localparam kind_t KIND_QUERY   = 2'd3;

  // Linear store address of entry (i, j) in layer l.
  function automatic addr_t store_addr(input layer_t l, input vidx_t i, input vidx_t j);
    logic [31:0] a;
    begin
      a = 32'(l) * 32'(PLANE) + 32'(i) * 32'(MAX_VERTICES) + 32'(j);
      store_addr = ADDR_W'(a);
    end
  endfunction

endpackage

[src/lapsp_ram.sv]
`timescale 1ns / 1ps

module lapsp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4352
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports, read-first.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[src/layered_all_pairs_shortest_paths.sv]
`timescale 1ns / 1ps
// Clear request: one store entry written per cycle, STORE_DEPTH entries in all.
// Edge request: a read and a conditional write back of one entry; nothing if ignored.
// Query request: store read, then result registered; held while out_stall is high.
// Compute request: for each row of each layer, a row setup step fetches the row pivot,
// then one update per entry reads the previous layer and writes this layer's entry.
// Reset clears control and sets vertex_count to 16; the store is undefined until a clear.

module layered_all_pairs_shortest_paths
  import lapsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [VTX_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] kind,
  input  logic [VTX_W-1:0]  src_vertex,
  input  logic [VTX_W-1:0]  dst_vertex,
  input  logic [WGT_W-1:0]  edge_weight,
  input  logic [VTX_W-1:0]  layer,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              reachable,
  output logic [DIST_W-1:0] distance
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CLEAR   = 4'd1;
  localparam logic [3:0] ST_EDGE_RD = 4'd2;
  localparam logic [3:0] ST_EDGE_WR = 4'd3;
  localparam logic [3:0] ST_QRD     = 4'd4;
  localparam logic [3:0] ST_QRES    = 4'd5;
  localparam logic [3:0] ST_ROW     = 4'd6;
  localparam logic [3:0] ST_COL     = 4'd7;
  localparam logic [3:0] ST_DRAIN   = 4'd8;

  logic [3:0]       state;
  logic [VTX_W-1:0] vertex_count;
  layer_t           n_eff;
  layer_t           n_last;

  // Per-request registers.
  addr_t            item_addr;
  logic             item_ok;
  logic [WGT_W-1:0] weight;

  // Sweep counters shared by clear and compute.
  layer_t lay;
  vidx_t  ri;
  vidx_t  cj;
  layer_t m_layer;
  vidx_t  m_idx;

  // Compute pipeline.
  logic   pend;
  addr_t  pend_addr;
  logic   via_load;
  dist_t  via_reg;

  // Store ports.
  logic   ram_we;
  addr_t  ram_waddr;
  dist_t  ram_wdata;
  addr_t  raddr_a;
  addr_t  raddr_b;
  dist_t  rdata_a;
  dist_t  rdata_b;

  logic   accept;
  logic   out_free;
  logic   src_ok;
  logic   dst_ok;
  layer_t q_layer;
  vidx_t  src_idx;
  vidx_t  dst_idx;

  logic [DIST_W:0] via_sum;
  dist_t           via_sat;
  dist_t           upd_val;

  // Effective vertex count: zero acts as one, large values clamp to the maximum.
  always_comb begin
    if (vertex_count == '0) begin
      n_eff = LAYER_W'(1);
    end else if (CMP_W'(vertex_count) > CMP_W'(MAX_VERTICES)) begin
      n_eff = LAYER_W'(MAX_VERTICES);
    end else begin
      n_eff = LAYER_W'(vertex_count);
    end
  end

  assign n_last  = n_eff - LAYER_W'(1);
  assign m_layer = lay - LAYER_W'(1);
  assign m_idx   = VIDX_W'(m_layer);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VTX_W'(16);
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  // Request decode helpers.
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign src_ok   = (src_vertex != '0) && (CMP_W'(src_vertex) <= CMP_W'(n_eff));
  assign dst_ok   = (dst_vertex != '0) && (CMP_W'(dst_vertex) <= CMP_W'(n_eff));
  assign src_idx  = VIDX_W'(CMP_W'(src_vertex) - CMP_W'(1));
  assign dst_idx  = VIDX_W'(CMP_W'(dst_vertex) - CMP_W'(1));
  assign q_layer  = (CMP_W'(layer) > CMP_W'(n_eff)) ? n_eff : LAYER_W'(layer);

  // Relaxation through the intermediate vertex, saturating at infinity.
  assign via_sum = {1'b0, via_reg} + {1'b0, rdata_b};
  assign via_sat = (via_sum > {1'b0, DIST_INF}) ? DIST_INF : via_sum[DIST_W-1:0];
  assign upd_val = (via_sat < rdata_a) ? via_sat : rdata_a;

  // Read address selection.
  always_comb begin
    raddr_a = item_addr;
    raddr_b = item_addr;
    unique case (state)
      ST_ROW: begin
        raddr_a = store_addr(m_layer, ri, m_idx);
      end
      ST_COL: begin
        raddr_a = store_addr(m_layer, ri, cj);
        raddr_b = store_addr(m_layer, m_idx, cj);
      end
      default: begin
        raddr_a = item_addr;
        raddr_b = item_addr;
      end
    endcase
  end

  // Write port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = upd_val;
    if (pend) begin
      ram_we = 1'b1;
    end else if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = store_addr(lay, ri, cj);
      ram_wdata = (ri == cj) ? '0 : DIST_INF;
    end else if (state == ST_EDGE_WR) begin
      ram_we    = item_ok && (DIST_W'(weight) < rdata_a);
      ram_waddr = item_addr;
      ram_wdata = DIST_W'(weight);
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pend     <= 1'b0;
      via_load <= 1'b0;
    end else begin
      pend     <= (state == ST_COL);
      via_load <= (state == ST_ROW);
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (kind)
              KIND_CLEAR: begin
                state <= ST_CLEAR;
              end
              KIND_EDGE: begin
                state <= (src_ok && dst_ok) ? ST_EDGE_RD : ST_IDLE;
              end
              KIND_COMPUTE: begin
                state <= ST_ROW;
              end
              KIND_QUERY: begin
                state <= ST_QRD;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          if ((ri == VIDX_W'(MAX_VERTICES - 1)) && (cj == VIDX_W'(MAX_VERTICES - 1))
              && (lay == LAYER_W'(MAX_VERTICES))) begin
            state <= ST_IDLE;
          end
        end
        ST_EDGE_RD: begin
          state <= ST_EDGE_WR;
        end
        ST_EDGE_WR: begin
          state <= ST_IDLE;
        end
        ST_QRD: begin
          state <= ST_QRES;
        end
        ST_QRES: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_ROW: begin
          state <= ST_COL;
        end
        ST_COL: begin
          if (LAYER_W'(cj) == n_last) begin
            if ((LAYER_W'(ri) == n_last) && (lay == n_eff)) begin
              state <= ST_DRAIN;
            end else begin
              state <= ST_ROW;
            end
          end
        end
        ST_DRAIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Sweep counters and request registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      item_ok   <= src_ok && dst_ok;
      weight    <= edge_weight;
      item_addr <= (src_ok && dst_ok)
                   ? store_addr((kind == KIND_QUERY) ? q_layer : '0, src_idx, dst_idx)
                   : '0;
      lay       <= (kind == KIND_COMPUTE) ? LAYER_W'(1) : '0;
      ri        <= '0;
      cj        <= '0;
    end else if (state == ST_CLEAR) begin
      if (cj == VIDX_W'(MAX_VERTICES - 1)) begin
        cj <= '0;
        if (ri == VIDX_W'(MAX_VERTICES - 1)) begin
          ri  <= '0;
          lay <= lay + LAYER_W'(1);
        end else begin
          ri <= ri + VIDX_W'(1);
        end
      end else begin
        cj <= cj + VIDX_W'(1);
      end
    end else if (state == ST_COL) begin
      pend_addr <= store_addr(lay, ri, cj);
      if (LAYER_W'(cj) == n_last) begin
        cj <= '0;
        if (LAYER_W'(ri) == n_last) begin
          ri  <= '0;
          lay <= lay + LAYER_W'(1);
        end else begin
          ri <= ri + VIDX_W'(1);
        end
      end else begin
        cj <= cj + VIDX_W'(1);
      end
    end
  end

  // Row pivot entry arrives the cycle after the row setup read.
  always_ff @(posedge clk) begin
    if (via_load) begin
      via_reg <= rdata_a;
    end
  end

  // Output register for query results.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_QRES && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_QRES && out_free) begin
      reachable <= item_ok && (rdata_a < DIST_INF);
      distance  <= (item_ok && (rdata_a < DIST_INF)) ? rdata_a : '0;
    end
  end

  lapsp_ram #(
    .WIDTH(DIST_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // The store is never written while the block is idle.
  assert property (@(posedge clk) disable iff (rst) (state == ST_IDLE) |-> !ram_we)
    else $error("store written while idle");

  // An unreachable result carries a zero distance.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reachable) |-> (distance == '0))
    else $error("unreachable result with nonzero distance");

  // A reachable result is always below infinity.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && reachable) |-> (distance < DIST_INF))
    else $error("reachable result at infinity");

  // Compute updates only follow a column read.
  assert property (@(posedge clk) disable iff (rst) pend |-> ($past(state) == ST_COL))
    else $error("update write without column read");

  // A new result only comes from the query result state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_QRES))
    else $error("result raised outside query");

endmodule
